>>> rtl/core/iqs_pkg.sv
// Shared constants and types for the iterative quicksort engine.
package iqs_pkg;
  localparam int unsigned MaxItems   = 32;
  localparam int unsigned ValueWidth = 32;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_RD_A,
    CMD_RD_B,
    CMD_WR_A,
    CMD_WR_B,
    CMD_EMIT
  } dp_cmd_e;
endpackage

>>> rtl/core/iqs_stream_if.sv
// Valid/ready stream interface carrying one value beat.
interface iqs_stream_if #(
  parameter int unsigned W = iqs_pkg::ValueWidth
);
  logic         valid;
  logic         ready;
  logic [W-1:0] value;
  logic         last;
  logic         final_res;
  logic         overflow;

  modport source (output valid, value, last, final_res, overflow, input ready);
  modport sink   (input valid, value, last, final_res, overflow, output ready);
endinterface

>>> rtl/core/iqs_datapath.sv
// Value store with a single shared-address read/write port, compare result and output data.
module iqs_datapath #(
  parameter int unsigned MAX_ITEMS   = iqs_pkg::MaxItems,
  parameter int unsigned VALUE_WIDTH = iqs_pkg::ValueWidth,
  localparam int unsigned IW = $clog2(MAX_ITEMS)
) (
  input  logic                   clk_i,
  input  iqs_pkg::dp_cmd_e       cmd_i,
  input  logic [IW-1:0]          addr_i,
  input  logic [VALUE_WIDTH-1:0] load_value_i,
  output logic                   a_gt_b_o,
  output logic [VALUE_WIDTH-1:0] rd_data_o
);
  logic [VALUE_WIDTH-1:0] mem [MAX_ITEMS];
  logic [VALUE_WIDTH-1:0] a_q, b_q, rd_q;

  always_ff @(posedge clk_i) begin
    rd_q <= mem[addr_i];
    unique case (cmd_i)
      iqs_pkg::CMD_LOAD: mem[addr_i] <= load_value_i;
      iqs_pkg::CMD_WR_A: mem[addr_i] <= b_q;
      iqs_pkg::CMD_WR_B: mem[addr_i] <= a_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      iqs_pkg::CMD_RD_A: a_q <= rd_q;
      iqs_pkg::CMD_RD_B: b_q <= rd_q;
      default: ;
    endcase
  end

  assign a_gt_b_o  = $signed(a_q) > $signed(b_q);
  assign rd_data_o = rd_q;
endmodule

>>> rtl/core/iqs_controller.sv
// Sequencer for load, range stack, partition, compare-swap and emit.
module iqs_controller #(
  parameter int unsigned MAX_ITEMS = iqs_pkg::MaxItems,
  localparam int unsigned IW = $clog2(MAX_ITEMS),
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             out_final_o,
  output logic             out_ovf_o,
  output logic             out_load_o,
  output iqs_pkg::dp_cmd_e cmd_o,
  output logic [IW-1:0]    addr_o,
  input  logic             a_gt_b_i
);
  typedef enum logic [3:0] {
    S_LOAD, S_POP, S_RDA, S_RDA2, S_RDB, S_RDB2, S_CMP, S_WRB,
    S_NEXT, S_EMIT_RD, S_EMIT_WAIT, S_EMIT
  } state_e;
  typedef enum logic [1:0] { M_PART, M_CS3A, M_CS3B, M_CS3C } mode_e;

  state_e          state_q;
  mode_e           mode_q;
  logic [CW-1:0]   count_q, k_q;
  logic            ovf_q;
  logic [IW-1:0]   lo_stk [MAX_ITEMS];
  logic [IW-1:0]   hi_stk [MAX_ITEMS];
  logic [CW-1:0]   sp_q;
  logic [IW-1:0]   lo_q, hi_q, p_q, j_q, ia_q, ib_q;
  logic            push2_q;

  logic in_fire, out_fire;
  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;
  assign in_ready_o  = (state_q == S_LOAD);
  assign out_load_o  = (state_q == S_EMIT_WAIT) || (state_q == S_EMIT && out_fire);

  always_comb begin
    cmd_o  = iqs_pkg::CMD_NONE;
    addr_o = ia_q;
    unique case (state_q)
      S_LOAD: begin
        addr_o = count_q[IW-1:0];
        if (in_fire && count_q < CW'(MAX_ITEMS)) cmd_o = iqs_pkg::CMD_LOAD;
      end
      S_RDA:  addr_o = ia_q;
      S_RDA2: begin addr_o = ib_q; cmd_o = iqs_pkg::CMD_RD_A; end
      S_RDB:  addr_o = ib_q;
      S_RDB2: begin addr_o = ib_q; cmd_o = iqs_pkg::CMD_RD_B; end
      S_CMP:  if (a_gt_b_i) begin addr_o = ia_q; cmd_o = iqs_pkg::CMD_WR_A; end
      S_WRB:  begin addr_o = ib_q; cmd_o = iqs_pkg::CMD_WR_B; end
      S_EMIT_RD, S_EMIT_WAIT, S_EMIT: addr_o = k_q[IW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      mode_q <= M_PART;
      count_q <= '0;
      k_q <= '0;
      ovf_q <= 1'b0;
      sp_q <= '0;
      out_valid_o <= 1'b0;
      out_final_o <= 1'b0;
      out_ovf_o <= 1'b0;
      push2_q <= 1'b0;
      lo_q <= '0; hi_q <= '0; p_q <= '0; j_q <= '0; ia_q <= '0; ib_q <= '0;
    end else begin
      unique case (state_q)
        S_LOAD: if (in_fire) begin
          if (count_q < CW'(MAX_ITEMS)) count_q <= count_q + 1'b1;
          else ovf_q <= 1'b1;
          if (in_last_i) begin
            state_q <= S_POP;
            if (count_q + (count_q < CW'(MAX_ITEMS) ? 1'b1 : 1'b0) >= CW'(2)) begin
              lo_stk[0] <= '0;
              hi_stk[0] <= IW'(count_q - (count_q < CW'(MAX_ITEMS) ? 1'b0 : 1'b1));
              sp_q <= CW'(1);
            end else sp_q <= '0;
          end
        end
        S_POP: begin
          k_q <= '0;
          if (sp_q == '0) state_q <= S_EMIT_RD;
          else begin
            lo_q <= lo_stk[sp_q[IW-1:0] - 1'b1];
            hi_q <= hi_stk[sp_q[IW-1:0] - 1'b1];
            sp_q <= sp_q - 1'b1;
            state_q <= S_NEXT;
            push2_q <= 1'b1;
          end
        end
        S_NEXT: begin
          if (push2_q) begin
            push2_q <= 1'b0;
            if ({1'b0, lo_q} + 3'd2 < {1'b0, hi_q}) begin
              mode_q <= M_PART; p_q <= lo_q; j_q <= hi_q;
              ia_q <= lo_q; ib_q <= hi_q; state_q <= S_RDA;
            end else if ({1'b0, lo_q} + 3'd2 == {1'b0, hi_q}) begin
              mode_q <= M_CS3A; ia_q <= lo_q; ib_q <= lo_q + 1'b1; state_q <= S_RDA;
            end else begin
              mode_q <= M_CS3C; ia_q <= lo_q; ib_q <= hi_q; state_q <= S_RDA;
            end
          end else begin
            unique case (mode_q)
              M_CS3A: begin
                mode_q <= M_CS3B; ia_q <= lo_q + 1'b1; ib_q <= hi_q; state_q <= S_RDA;
              end
              M_CS3B: begin
                mode_q <= M_CS3C; ia_q <= lo_q; ib_q <= lo_q + 1'b1; state_q <= S_RDA;
              end
              M_CS3C: state_q <= S_POP;
              M_PART: begin
                if (p_q == j_q) begin
                  if (p_q < hi_q && p_q + 1'b1 < hi_q) begin
                    lo_stk[sp_q[IW-1:0]] <= p_q + 1'b1;
                    hi_stk[sp_q[IW-1:0]] <= hi_q;
                    if (p_q > lo_q + 1'b1) begin
                      lo_stk[sp_q[IW-1:0] + 1'b1] <= lo_q;
                      hi_stk[sp_q[IW-1:0] + 1'b1] <= p_q - 1'b1;
                      sp_q <= sp_q + CW'(2);
                    end else sp_q <= sp_q + 1'b1;
                  end else if (p_q > lo_q + 1'b1) begin
                    lo_stk[sp_q[IW-1:0]] <= lo_q;
                    hi_stk[sp_q[IW-1:0]] <= p_q - 1'b1;
                    sp_q <= sp_q + 1'b1;
                  end
                  state_q <= S_POP;
                end else begin
                  ia_q <= (p_q < j_q) ? p_q : j_q;
                  ib_q <= (p_q < j_q) ? j_q : p_q;
                  state_q <= S_RDA;
                end
              end
              default: state_q <= S_POP;
            endcase
          end
        end
        S_RDA:  state_q <= S_RDA2;
        S_RDA2: state_q <= S_RDB;
        S_RDB:  state_q <= S_RDB2;
        S_RDB2: state_q <= S_CMP;
        S_CMP: begin
          if (a_gt_b_i) state_q <= S_WRB;
          else begin
            state_q <= S_NEXT;
            if (mode_q == M_PART) begin
              if (p_q < j_q) j_q <= j_q - 1'b1;
              else j_q <= j_q + 1'b1;
            end
          end
        end
        S_WRB: begin
          state_q <= S_NEXT;
          if (mode_q == M_PART) begin
            p_q <= j_q;
            if (p_q < j_q) j_q <= p_q + 1'b1;
            else j_q <= p_q - 1'b1;
          end
        end
        S_EMIT_RD: begin
          if (count_q == '0) begin
            state_q <= S_LOAD; ovf_q <= 1'b0;
          end else begin
            state_q <= S_EMIT_WAIT;
          end
        end
        S_EMIT_WAIT: begin
          out_valid_o <= 1'b1;
          out_final_o <= (k_q + 1'b1 == count_q);
          out_ovf_o <= ovf_q;
          k_q <= k_q + 1'b1;
          state_q <= S_EMIT;
        end
        S_EMIT: if (out_fire) begin
          out_valid_o <= 1'b0;
          if (k_q == count_q) begin
            state_q <= S_LOAD; count_q <= '0; ovf_q <= 1'b0; sp_q <= '0;
          end else state_q <= S_EMIT_RD;
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end
endmodule

>>> rtl/core/iterative_quicksort_engine.sv
// Top level of the iterative quicksort engine.
// Usage:
//   in_if carries one signed value per beat; last marks the final value of a set.
//   Up to MAX_ITEMS values are held; later ones are dropped and overflow is set.
//   After last the input stalls while the set is sorted in place by a
//   non-recursive quicksort over an explicit range stack.
//   out_if then gives the values in ascending order, final_res on the last.
// Timing:
//   Loading takes one cycle per beat. Each compare-exchange reads both
//   values through the single store port, compares them and writes them
//   back swapped when the first is greater.
//   Each output beat is read from the store, registered and held until taken.
// Reset:
//   Reset clears counters, stack pointer and the overflow flag; the value
//   store is not cleared. A stalled receiver holds the output beat and
//   the block waits; no input is taken until the whole set is delivered.
module iterative_quicksort_engine #(
  parameter int unsigned MAX_ITEMS   = iqs_pkg::MaxItems,
  parameter int unsigned VALUE_WIDTH = iqs_pkg::ValueWidth
) (
  input logic        clk_i,
  input logic        rst_ni,
  iqs_stream_if.sink   in_if,
  iqs_stream_if.source out_if
);
  localparam int unsigned IW = $clog2(MAX_ITEMS);

  iqs_pkg::dp_cmd_e       cmd;
  logic [IW-1:0]          addr;
  logic                   a_gt_b;
  logic [VALUE_WIDTH-1:0] rd_data;
  logic                   out_load;
  logic [VALUE_WIDTH-1:0] out_value_q;

  iqs_controller #(.MAX_ITEMS(MAX_ITEMS)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_last_i  (in_if.last),
    .in_ready_o (in_if.ready),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .out_final_o(out_if.final_res),
    .out_ovf_o  (out_if.overflow),
    .out_load_o (out_load),
    .cmd_o      (cmd),
    .addr_o     (addr),
    .a_gt_b_i   (a_gt_b)
  );

  iqs_datapath #(.MAX_ITEMS(MAX_ITEMS), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk_i,
    .cmd_i       (cmd),
    .addr_i      (addr),
    .load_value_i(in_if.value),
    .a_gt_b_o    (a_gt_b),
    .rd_data_o   (rd_data)
  );

  always_ff @(posedge clk_i) begin
    if (out_load && !out_if.valid) out_value_q <= rd_data;
  end
  assign out_if.value = out_value_q;
  assign out_if.last  = out_if.final_res;

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_if.ready && out_if.valid)) else $error("input open during output");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> $stable(out_if.value))
    else $error("output value changed while stalled");
`endif
endmodule
